### sv/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg: shared types and constants of the lfu frame replacement core
// Slot geometry, field widths, the search packet that walks the cell chain
// and the write-back command that is broadcast to the cells.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int MAX_SLOTS = 32;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int ID_W      = 8;
  localparam int CNT_W     = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 6;

  typedef enum logic [1:0] {
    ACT_HIT     = 2'd0,
    ACT_PLACE   = 2'd1,
    ACT_REPLACE = 2'd2
  } lfr_action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } lfr_state_t;

  // search packet, advanced one cell per cycle
  typedef struct packed {
    logic              live;
    logic [ID_W-1:0]   cand;
    logic              found;
    logic              hit;
    logic [IDX_W-1:0]  found_idx;
    logic [CNT_W-1:0]  found_count;
    logic              best_valid;
    logic [IDX_W-1:0]  best_idx;
    logic [ID_W-1:0]   best_id;
    logic [CNT_W-1:0]  best_count;
    logic [TIME_W-1:0] best_time;
  } lfr_pkt_t;

  // write-back command, taken by the cell whose index matches
  typedef struct packed {
    logic              en;
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] stamp;
  } lfr_wr_t;

endpackage

### sv/lfr_cell.sv
// ----------------------------------------------------------------------------
// lfr_cell: one slot of the replacement chain
// Holds id, use count and insertion time of one slot, folds its contents
// into the passing search packet and hands the packet to the next cell.
// ----------------------------------------------------------------------------
module lfr_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lfr_pkg::IDX_W-1:0]  cell_idx,
  input  logic                       active,
  input  lfr_pkg::lfr_pkt_t          pkt_in,
  input  lfr_pkg::lfr_wr_t           wr,
  output lfr_pkg::lfr_pkt_t          pkt_out
);

  logic [lfr_pkg::ID_W-1:0]   id_r;
  logic [lfr_pkg::CNT_W-1:0]  count_r;
  logic [lfr_pkg::TIME_W-1:0] time_r;
  lfr_pkg::lfr_pkt_t          pkt_r;
  lfr_pkg::lfr_pkt_t          pkt_nxt;
  logic                       wr_here;
  logic                       better;

  assign wr_here = wr.en && (wr.idx == cell_idx);

  // lower count wins, then older insertion; equal keeps the earlier slot
  assign better = !pkt_in.best_valid || (count_r < pkt_in.best_count) ||
                  ((count_r == pkt_in.best_count) && (time_r < pkt_in.best_time));

  always_comb begin
    pkt_nxt = pkt_in;
    if (active && !pkt_in.found) begin
      if (id_r == '0) begin
        pkt_nxt.found     = 1'b1;
        pkt_nxt.hit       = 1'b0;
        pkt_nxt.found_idx = cell_idx;
      end else if (id_r == pkt_in.cand) begin
        pkt_nxt.found       = 1'b1;
        pkt_nxt.hit         = 1'b1;
        pkt_nxt.found_idx   = cell_idx;
        pkt_nxt.found_count = count_r;
      end
    end
    if (active && better) begin
      pkt_nxt.best_valid = 1'b1;
      pkt_nxt.best_idx   = cell_idx;
      pkt_nxt.best_id    = id_r;
      pkt_nxt.best_count = count_r;
      pkt_nxt.best_time  = time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r    <= '0;
      count_r <= '0;
      time_r  <= '0;
    end else if (wr_here) begin
      id_r    <= wr.id;
      count_r <= wr.count;
      if (!wr.hit) begin
        time_r <= wr.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r.live <= 1'b0;
    end else begin
      pkt_r.live <= pkt_nxt.live;
    end
    pkt_r.cand        <= pkt_nxt.cand;
    pkt_r.found       <= pkt_nxt.found;
    pkt_r.hit         <= pkt_nxt.hit;
    pkt_r.found_idx   <= pkt_nxt.found_idx;
    pkt_r.found_count <= pkt_nxt.found_count;
    pkt_r.best_valid  <= pkt_nxt.best_valid;
    pkt_r.best_idx    <= pkt_nxt.best_idx;
    pkt_r.best_id     <= pkt_nxt.best_id;
    pkt_r.best_count  <= pkt_nxt.best_count;
    pkt_r.best_time   <= pkt_nxt.best_time;
  end

  assign pkt_out = pkt_r;

endmodule

### sv/lfu_frame_replacement_core.sv
// ----------------------------------------------------------------------------
// lfu_frame_replacement_core: lfu slot replacement, oldest insertion tie break
// Candidate ids enter on the in_ channel; one result per non-zero id leaves
// on the out_ channel. The slots live in a chain of cells that a search
// packet walks, one cell per cycle.
// ----------------------------------------------------------------------------
// usage:
//   in_  : in_candidate_id, valid/ready. an id of zero is taken and dropped
//          with no result.
//   out_ : action, slot index, evicted id and use count, valid/ready.
//   cfg_ : slots_in_use, valid/ready, always ready; write only while idle.
// timing:
//   one item at a time. the search packet passes every cell in turn, then
//   the tail packet is captured and the write-back loads the slots and the
//   output register; the result is valid, and a new item can be taken, once
//   that write-back is done. an output stall holds the write-back.
// reset:
//   synchronous, active low: all slots empty, counts, times and step zero,
//   slots_in_use back to 32.
// stall:
//   a result waits in the output register; the next result holds in the
//   write-back stage, keeping the slots untouched, until that register frees.
// ----------------------------------------------------------------------------
module lfu_frame_replacement_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lfr_pkg::ID_W-1:0]   in_candidate_id,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_action,
  output logic [4:0]                 out_slot_index,
  output logic [lfr_pkg::ID_W-1:0]   out_evicted_id,
  output logic [lfr_pkg::CNT_W-1:0]  out_use_count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lfr_pkg::CFG_W-1:0]  cfg_data
);

  lfr_pkg::lfr_state_t          state_r;
  lfr_pkg::lfr_state_t          state_nxt;
  logic [lfr_pkg::CFG_W-1:0]    slots_r;
  logic [lfr_pkg::CFG_W-1:0]    n_eff;
  logic [lfr_pkg::TIME_W-1:0]   step_r;
  lfr_pkg::lfr_pkt_t            chain [lfr_pkg::MAX_SLOTS+1];
  lfr_pkg::lfr_pkt_t            res_r;
  lfr_pkg::lfr_wr_t             wr;
  logic [lfr_pkg::MAX_SLOTS-1:0] active;
  logic [lfr_pkg::MAX_SLOTS-1:0] live_vec;
  logic                         in_xfer;
  logic                         wb_fire;
  logic                         res_hit;
  lfr_pkg::lfr_action_t         res_action;
  logic [lfr_pkg::IDX_W-1:0]    res_pick;
  logic [lfr_pkg::CNT_W-1:0]    res_count;
  logic [lfr_pkg::ID_W-1:0]     res_evicted;
  logic                         out_valid_r;
  lfr_pkg::lfr_action_t         out_action_r;
  logic [lfr_pkg::IDX_W-1:0]    out_slot_r;
  logic [lfr_pkg::ID_W-1:0]     out_evicted_r;
  logic [lfr_pkg::CNT_W-1:0]    out_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= lfr_pkg::CFG_W'(lfr_pkg::MAX_SLOTS);
    end else if (cfg_valid && cfg_ready) begin
      slots_r <= cfg_data;
    end
  end

  always_comb begin
    if (slots_r == '0) begin
      n_eff = lfr_pkg::CFG_W'(1);
    end else if (slots_r > lfr_pkg::CFG_W'(lfr_pkg::MAX_SLOTS)) begin
      n_eff = lfr_pkg::CFG_W'(lfr_pkg::MAX_SLOTS);
    end else begin
      n_eff = slots_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lfr_pkg::ST_IDLE: begin
        if (in_valid && (in_candidate_id != '0)) begin
          state_nxt = lfr_pkg::ST_SCAN;
        end
      end
      lfr_pkg::ST_SCAN: begin
        if (chain[lfr_pkg::MAX_SLOTS].live) begin
          state_nxt = lfr_pkg::ST_FIN;
        end
      end
      lfr_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = lfr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lfr_pkg::ST_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    wb_fire  = 1'b0;
    case (state_r)
      lfr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      lfr_pkg::ST_SCAN: begin
        in_ready = 1'b0;
      end
      lfr_pkg::ST_FIN: begin
        wb_fire = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_xfer = in_valid && in_ready;

  // head of the chain: a fresh packet on a transfer of a non-zero id
  always_comb begin
    chain[0]       = '0;
    chain[0].live  = in_xfer && (in_candidate_id != '0);
    chain[0].cand  = in_candidate_id;
  end

  for (genvar k = 0; k < lfr_pkg::MAX_SLOTS; k++) begin : g_cell
    assign active[k]   = lfr_pkg::CFG_W'(k) < n_eff;
    assign live_vec[k] = chain[k+1].live;
    lfr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (lfr_pkg::IDX_W'(k)),
      .active   (active[k]),
      .pkt_in   (chain[k]),
      .wr       (wr),
      .pkt_out  (chain[k+1])
    );
  end

  // tail packet is live for a single cycle, so hold it for write-back
  always_ff @(posedge clk) begin
    if ((state_r == lfr_pkg::ST_SCAN) && chain[lfr_pkg::MAX_SLOTS].live) begin
      res_r <= chain[lfr_pkg::MAX_SLOTS];
    end
  end

  assign res_hit = res_r.found && res_r.hit;

  always_comb begin
    if (res_r.found) begin
      res_action = res_r.hit ? lfr_pkg::ACT_HIT : lfr_pkg::ACT_PLACE;
      res_pick   = res_r.found_idx;
    end else begin
      res_action = lfr_pkg::ACT_REPLACE;
      res_pick   = res_r.best_idx;
    end
    res_evicted = res_r.found ? '0 : res_r.best_id;
    if (res_hit) begin
      res_count = (res_r.found_count == '1) ? res_r.found_count
                                            : res_r.found_count + 1'b1;
    end else begin
      res_count = lfr_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    wr.en    = wb_fire;
    wr.hit   = res_hit;
    wr.idx   = res_pick;
    wr.id    = res_r.cand;
    wr.count = res_count;
    wr.stamp = step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (wb_fire && (step_r != '1)) begin
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      out_action_r  <= res_action;
      out_slot_r    <= res_pick;
      out_evicted_r <= res_evicted;
      out_count_r   <= res_count;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_slot_index = 5'(out_slot_r);
  assign out_evicted_id = out_evicted_r;
  assign out_use_count  = out_count_r;

  // only one search packet in flight
  a_one_packet: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(live_vec) <= 1)
    else $error("more than one live search packet");

  // the tail packet only arrives while scanning
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chain[lfr_pkg::MAX_SLOTS].live |-> (state_r == lfr_pkg::ST_SCAN))
    else $error("search packet left the chain outside a scan");

  // a replacement always removes a held id and every result has a count
  a_replace_evicts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_count_r != '0) &&
                     ((out_action_r != lfr_pkg::ACT_REPLACE) || (out_evicted_r != '0))))
    else $error("bad result: zero count or empty victim");

endmodule

### bench/lfu_frame_replacement_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_frame_replacement_core_tb: self-checking bench for the lfu slot core
// A queue-fed driver sends candidate ids in random bursts while the result
// side stalls on its own pattern. Each non-zero transfer in is run through a local
// slot model and the predicted outcome is matched against every result.
// ----------------------------------------------------------------------------
module lfu_frame_replacement_core_tb;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 195;

  typedef struct {
    lfr_pkg::lfr_action_t       action;
    logic [lfr_pkg::IDX_W-1:0]  slot;
    logic [lfr_pkg::ID_W-1:0]   evicted;
    logic [lfr_pkg::CNT_W-1:0]  count;
  } lfu_outcome_t;

  logic                       clk;
  logic                       rst_n           = 1'b0;
  logic                       in_valid        = 1'b0;
  logic                       in_ready;
  logic [lfr_pkg::ID_W-1:0]   in_candidate_id = '0;
  logic                       out_valid;
  logic                       out_ready       = 1'b0;
  logic [1:0]                 out_action;
  logic [4:0]                 out_slot_index;
  logic [lfr_pkg::ID_W-1:0]   out_evicted_id;
  logic [lfr_pkg::CNT_W-1:0]  out_use_count;
  logic                       cfg_valid       = 1'b0;
  logic                       cfg_ready;
  logic [lfr_pkg::CFG_W-1:0]  cfg_data        = '0;

  // local copy of the slot store
  logic [lfr_pkg::ID_W-1:0]   pred_id    [lfr_pkg::MAX_SLOTS];
  logic [lfr_pkg::CNT_W-1:0]  pred_count [lfr_pkg::MAX_SLOTS];
  logic [lfr_pkg::TIME_W-1:0] pred_stamp [lfr_pkg::MAX_SLOTS];
  logic [lfr_pkg::TIME_W-1:0] pred_step;
  logic [lfr_pkg::CFG_W-1:0]  pred_slots_cfg;

  logic [lfr_pkg::ID_W-1:0] candidate_queue [$];
  lfu_outcome_t             awaited_results [$];
  int                       mismatch_count = 0;
  int                       quiet_cycles   = 0;

  lfu_frame_replacement_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_candidate_id (in_candidate_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_action      (out_action),
    .out_slot_index  (out_slot_index),
    .out_evicted_id  (out_evicted_id),
    .out_use_count   (out_use_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hit, first empty slot, or lfu victim with oldest stamp winning ties
  function automatic lfu_outcome_t apply_candidate(logic [lfr_pkg::ID_W-1:0] id);
    lfu_outcome_t res;
    int           n;
    int           pick;
    bit           done;
    res.action  = lfr_pkg::ACT_REPLACE;
    res.evicted = '0;
    pick        = 0;
    done        = 1'b0;
    if (pred_slots_cfg == 0) n = 1;
    else if (pred_slots_cfg > lfr_pkg::MAX_SLOTS) n = lfr_pkg::MAX_SLOTS;
    else n = int'(pred_slots_cfg);
    for (int j = 0; j < n; j++) begin
      if (!done && pred_id[j] == '0) begin
        res.action = lfr_pkg::ACT_PLACE;
        pick       = j;
        done       = 1'b1;
      end else if (!done && pred_id[j] == id) begin
        res.action = lfr_pkg::ACT_HIT;
        pick       = j;
        done       = 1'b1;
      end
    end
    if (res.action == lfr_pkg::ACT_HIT) begin
      if (pred_count[pick] != '1) pred_count[pick]++;
    end else begin
      if (res.action == lfr_pkg::ACT_REPLACE) begin
        pick = 0;
        for (int j = 1; j < n; j++) begin
          if (pred_count[j] < pred_count[pick] ||
              (pred_count[j] == pred_count[pick] && pred_stamp[j] < pred_stamp[pick]))
            pick = j;
        end
        res.evicted = pred_id[pick];
      end
      pred_id[pick]    = id;
      pred_count[pick] = lfr_pkg::CNT_W'(1);
      pred_stamp[pick] = pred_step;
    end
    if (pred_step != '1) pred_step++;
    res.slot  = pick[lfr_pkg::IDX_W-1:0];
    res.count = pred_count[pick];
    return res;
  endfunction

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin : drive
    int           gap_left;
    int           burst_left;
    logic         nxt_valid;
    lfu_outcome_t res;
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_candidate_id <= '0;
      gap_left        = 0;
      burst_left      = 0;
      pred_step       = '0;
      pred_slots_cfg  = lfr_pkg::CFG_W'(lfr_pkg::MAX_SLOTS);
      for (int k = 0; k < lfr_pkg::MAX_SLOTS; k++) begin
        pred_id[k]    = '0;
        pred_count[k] = '0;
        pred_stamp[k] = '0;
      end
    end else begin
      // a reserved id is swallowed with no result
      if (in_valid && in_ready && in_candidate_id != '0) begin
        res = apply_candidate(in_candidate_id);
        awaited_results.insert(awaited_results.size(), res);
      end
      if (!in_valid || in_ready) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (candidate_queue.size() > 0) begin
          nxt_valid = 1'b1;
          in_candidate_id <= candidate_queue.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 70);
          end
        end
        in_valid <= nxt_valid;
      end
    end
  end

  // receiver: calm stretches alternate with stretches of random stalls
  always @(posedge clk) begin : sink
    int stall_left;
    int mode_cycles;
    bit stall_mode;
    if (!rst_n) begin
      out_ready   <= 1'b0;
      stall_left  = 0;
      mode_cycles = 0;
      stall_mode  = 1'b0;
    end else begin
      mode_cycles++;
      if (mode_cycles == 700) begin
        mode_cycles = 0;
        stall_mode  = !stall_mode;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stall_mode && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 45);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check
    lfu_outcome_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: action %0d slot %0d evicted %0d count %0d",
               out_action, out_slot_index, out_evicted_id, out_use_count);
        mismatch_count++;
      end else begin
        exp_res = awaited_results.pop_front();
        if (out_action !== exp_res.action) begin
          $error("action: expected %0d, got %0d", exp_res.action, out_action);
          mismatch_count++;
        end
        if (out_slot_index !== exp_res.slot) begin
          $error("slot_index: expected %0d, got %0d", exp_res.slot, out_slot_index);
          mismatch_count++;
        end
        if (out_evicted_id !== exp_res.evicted) begin
          $error("evicted_id: expected %0d, got %0d", exp_res.evicted, out_evicted_id);
          mismatch_count++;
        end
        if (out_use_count !== exp_res.count) begin
          $error("use_count: expected %0d, got %0d", exp_res.count, out_use_count);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("lfu_frame_replacement_core verification failed");
        $finish;
      end
    end
  end

  // all ids sent, all results back, then let any dropped id clear the core
  task automatic wait_quiet();
    do @(negedge clk);
    while (candidate_queue.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_slots_in_use(logic [lfr_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    pred_slots_cfg = value;
    cfg_valid <= 1'b0;
  endtask

  // ids mostly from a window a little wider than the active slots, so hits
  // and evictions both come often; some repeats push counts up
  task automatic queue_random_ids(int count, int span);
    int                       base;
    int                       roll;
    int                       rep;
    int                       sent;
    logic [lfr_pkg::ID_W-1:0] id;
    base = $urandom_range(1, 256 - span);
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) id = '0;
      else if (roll < 13) id = lfr_pkg::ID_W'($urandom_range(1, 255));
      else id = lfr_pkg::ID_W'(base + int'($urandom_range(0, span - 1)));
      rep = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 6) : 1;
      repeat (rep) begin
        candidate_queue.insert(candidate_queue.size(), id);
        if (id != '0) sent++;
      end
    end
  endtask

  initial begin
    logic [lfr_pkg::CFG_W-1:0] phase_cfg [10];
    int                        n;
    phase_cfg = '{6'd1, 6'd4, 6'd32, 6'd63, 6'd0, 6'd33, 6'd8, 6'd2, 6'd16, 6'd20};
    phase_cfg[9] = lfr_pkg::CFG_W'($urandom_range(0, 63));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // all slots active after reset: placement, hits, reserved id, every id bit
    candidate_queue = '{8'd1, 8'd255, 8'd0, 8'd1, 8'd255, 8'h55, 8'hAA, 8'h80, 8'h7F};
    wait_quiet();
    // zero acts as one slot: evictions of slot 0 around a hit
    write_slots_in_use(6'd0);
    candidate_queue = '{8'd9, 8'd9, 8'd10};
    wait_quiet();
    // two slots, the inactive ones keep their ids for later
    write_slots_in_use(6'd2);
    candidate_queue = '{8'd3, 8'd3, 8'd4, 8'd5};
    wait_quiet();
    // above the slot count acts as all slots: old ids still held
    write_slots_in_use(6'd63);
    candidate_queue = '{8'h7F, 8'd200};
    wait_quiet();

    foreach (phase_cfg[p]) begin
      write_slots_in_use(phase_cfg[p]);
      if (phase_cfg[p] == 0) n = 1;
      else if (phase_cfg[p] > lfr_pkg::MAX_SLOTS) n = lfr_pkg::MAX_SLOTS;
      else n = int'(phase_cfg[p]);
      queue_random_ids(PHASE_ITEMS, n + n / 2 + 1);
      wait_quiet();
    end

    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("lfu_frame_replacement_core verification clean");
    else
      $display("lfu_frame_replacement_core verification failed");
    $finish;
  end

endmodule

### filelist.f
sv/lfr_pkg.sv
sv/lfr_cell.sv
sv/lfu_frame_replacement_core.sv
bench/lfu_frame_replacement_core_tb.sv
